[src/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg
// Shared types and codes for the circular byte FIFO with delimiter pop:
// operation codes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package brf_pkg;

   // Operation codes carried on req_kind
   localparam logic [1:0] KIND_PUSH      = 2'd0;
   localparam logic [1:0] KIND_POP       = 2'd1;
   localparam logic [1:0] KIND_POP_UNTIL = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;         // latch a new request
      logic push;         // store one byte and report
      logic emit_none;    // report a result without a byte
      logic scan_step;    // read and compare the next stored byte
      logic scan_finish;  // close the delimiter scan, prepare the run
      logic pop_step;     // read and transfer run bytes
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic n_zero;       // run length of the presented request is zero
      logic scan_hit;     // delimiter matched in this cycle
      logic scan_end;     // last byte in range compared in this cycle
      logic pop_done;     // last byte of the run transferred in this cycle
   } dp_stat_type;

endpackage

[src/byte_ring_fifo_with_delimiter_pop.sv]
// Push: result strobe follows start through ST_PUSH and the result register; next start accepted in that cycle.
// Pop of n bytes: one byte transfer per cycle, the first after ST_POP, the read register and the result register;
//   the single memory read port sets this rate. Empty or zero runs: via ST_EMPTY and the result register.
// Pop-until: a scan of one stored byte per cycle precedes the run.
// Synchronous active-high reset empties the ring; stored bytes are not cleared.
// Results are strobed for one cycle each; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_delimiter_pop
// Circular byte FIFO with push, run pop and pop-until-delimiter, built as a
// controller state machine driving a ring-buffer datapath.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_delimiter_pop #(
   parameter int DEPTH   = 256,
   parameter int MAX_RUN = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_in_byte,
   input  logic [6:0] req_max_count,
   input  logic [7:0] req_delimiter,
   output logic       rsp_strobe,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_last,
   output logic       rsp_accepted,
   output logic       rsp_found,
   output logic [7:0] rsp_level
);
   import brf_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequence the operations
   brf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_kind (req_kind),
      .stat     (stat),
      .cmd      (cmd),
      .busy     (busy)
   );

   // Store, scan and transfer bytes
   brf_datapath #(
      .DEPTH   (DEPTH),
      .MAX_RUN (MAX_RUN)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_in_byte    (req_in_byte),
      .req_max_count  (req_max_count),
      .req_delimiter  (req_delimiter),
      .rsp_strobe     (rsp_strobe),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_byte_valid (rsp_byte_valid),
      .rsp_last       (rsp_last),
      .rsp_accepted   (rsp_accepted),
      .rsp_found      (rsp_found),
      .rsp_level      (rsp_level)
   );

endmodule

[src/brf_ctrl.sv]
// ----------------------------------------------------------------------------
// brf_ctrl
// Controller state machine: sequences push, delimiter scan and run pop,
// and drives the datapath by commands.
// ----------------------------------------------------------------------------
module brf_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_kind,
   input  brf_pkg::dp_stat_type stat,
   output brf_pkg::dp_cmd_type  cmd,
   output logic               busy
);
   import brf_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_EMPTY,
      ST_SCAN,
      ST_POP
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Decode next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               case (req_kind)
                  KIND_PUSH: begin
                     state_in = ST_PUSH;
                  end
                  KIND_POP: begin
                     state_in = stat.n_zero ? ST_EMPTY : ST_POP;
                  end
                  KIND_POP_UNTIL: begin
                     state_in = stat.n_zero ? ST_EMPTY : ST_SCAN;
                  end
                  default: begin
                     state_in = ST_EMPTY;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_EMPTY: begin
            cmd.emit_none = 1'b1;
            state_in      = ST_IDLE;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_hit || stat.scan_end) begin
               cmd.scan_finish = 1'b1;
               state_in        = ST_POP;
            end
         end
         ST_POP: begin
            cmd.pop_step = 1'b1;
            if (stat.pop_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

[src/brf_datapath.sv]
// ----------------------------------------------------------------------------
// brf_datapath
// Byte ring storage with write/read pointers and a fill counter, the
// delimiter scan counters and the registered result port.
// ----------------------------------------------------------------------------
module brf_datapath #(
   parameter int DEPTH   = 256,
   parameter int MAX_RUN = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  brf_pkg::dp_cmd_type  cmd,
   output brf_pkg::dp_stat_type stat,
   input  logic [7:0]           req_in_byte,
   input  logic [6:0]           req_max_count,
   input  logic [7:0]           req_delimiter,
   output logic                 rsp_strobe,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_byte_valid,
   output logic                 rsp_last,
   output logic                 rsp_accepted,
   output logic                 rsp_found,
   output logic [7:0]           rsp_level
);
   import brf_pkg::*;

   localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(MAX_RUN + 1);
   localparam int CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;
   localparam int LVL_W = (PTR_W > 8) ? PTR_W : 8;

   // Storage
   logic [7:0]       mem [DEPTH];
   logic [7:0]       rd_data_ff;
   logic [PTR_W-1:0] rd_addr;

   // Pointers and fill level
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic [PTR_W-1:0] scan_ptr_ff, scan_ptr_in;
   logic [PTR_W-1:0] level_ff, level_in;
   logic [LVL_W-1:0] level_ext;

   // Request and run bookkeeping
   logic [7:0]       byte_ff;
   logic [7:0]       delim_ff;
   logic [CNT_W-1:0] run_len_ff, run_len_in;
   logic [CNT_W-1:0] iss_cnt_ff, iss_cnt_in;
   logic [CNT_W-1:0] cmp_cnt_ff, cmp_cnt_in;
   logic             pend_ff, pend_in;
   logic             found_ff, found_in;

   logic [CNT_W-1:0] clip;
   logic [CNT_W-1:0] n_now;
   logic [CNT_W-1:0] cmp_next;
   logic             full;
   logic             iss_en;
   logic             wr_en;
   logic             emit_byte;
   logic             hit;
   logic             cmp_last;

   // Result registers
   logic             strobe_ff, strobe_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic             byte_valid_ff, byte_valid_in;
   logic             last_ff, last_in;
   logic             accepted_ff, accepted_in;
   logic             found_out_ff, found_out_in;
   logic [7:0]       level_out_ff, level_out_in;

   // Clip the count and bound it by the fill level
   always_comb begin
      if (req_max_count > 7'(MAX_RUN)) begin
         clip = CNT_W'(MAX_RUN);
      end else begin
         clip = CNT_W'(req_max_count);
      end
      if (CMP_W'(level_ff) < CMP_W'(clip)) begin
         n_now = CNT_W'(level_ff);
      end else begin
         n_now = clip;
      end
   end

   assign full      = (level_ff == PTR_W'(DEPTH - 1));
   assign wr_en     = cmd.push && !full;
   assign iss_en    = (cmd.scan_step || cmd.pop_step) && (iss_cnt_ff != run_len_ff);
   assign emit_byte = cmd.pop_step && pend_ff;
   assign cmp_next  = cmp_cnt_ff + CNT_W'(1);
   assign cmp_last  = (cmp_next == run_len_ff);
   assign hit       = cmd.scan_step && pend_ff && (rd_data_ff == delim_ff);
   assign rd_addr   = cmd.pop_step ? rp_ff : scan_ptr_ff;

   assign stat.n_zero   = (n_now == '0);
   assign stat.scan_hit = hit;
   assign stat.scan_end = cmd.scan_step && pend_ff && cmp_last;
   assign stat.pop_done = emit_byte && cmp_last;

   // Advance pointers, level and counters
   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      scan_ptr_in = scan_ptr_ff;
      level_in    = level_ff;
      run_len_in  = run_len_ff;
      iss_cnt_in  = iss_cnt_ff;
      cmp_cnt_in  = cmp_cnt_ff;
      pend_in     = iss_en;
      found_in    = found_ff;

      if (wr_en) begin
         wp_in    = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
         level_in = level_ff + PTR_W'(1);
      end

      if (iss_en) begin
         iss_cnt_in = iss_cnt_ff + CNT_W'(1);
         if (cmd.pop_step) begin
            rp_in = (rp_ff == PTR_W'(DEPTH - 1)) ? '0 : rp_ff + PTR_W'(1);
         end else begin
            scan_ptr_in = (scan_ptr_ff == PTR_W'(DEPTH - 1)) ? '0
                                                               : scan_ptr_ff + PTR_W'(1);
         end
      end

      if (pend_ff && (cmd.scan_step || cmd.pop_step)) begin
         cmp_cnt_in = cmp_next;
      end

      if (emit_byte) begin
         level_in = level_ff - PTR_W'(1);
      end

      // Close the scan: cut the run at the match and restart the counters
      if (cmd.scan_finish) begin
         if (hit) begin
            run_len_in = cmp_next;
            found_in   = 1'b1;
         end
         iss_cnt_in = '0;
         cmp_cnt_in = '0;
         pend_in    = 1'b0;
      end

      if (cmd.load) begin
         scan_ptr_in = rp_ff;
         run_len_in  = n_now;
         iss_cnt_in  = '0;
         cmp_cnt_in  = '0;
         pend_in     = 1'b0;
         found_in    = 1'b0;
      end
   end

   assign level_ext = LVL_W'(level_in);

   // Build the next result
   always_comb begin
      strobe_in     = cmd.push || cmd.emit_none || emit_byte;
      out_byte_in   = emit_byte ? rd_data_ff : 8'd0;
      byte_valid_in = emit_byte;
      last_in       = cmd.push || cmd.emit_none || (emit_byte && cmp_last);
      accepted_in   = wr_en;
      found_out_in  = (emit_byte || cmd.emit_none) ? found_ff : 1'b0;
      level_out_in  = level_ext[7:0];
   end

   // Write and read the byte ring
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wp_ff] <= byte_ff;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff       <= '0;
         rp_ff       <= '0;
         scan_ptr_ff <= '0;
         level_ff    <= '0;
         run_len_ff  <= '0;
         iss_cnt_ff  <= '0;
         cmp_cnt_ff  <= '0;
         pend_ff     <= 1'b0;
         found_ff    <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
         scan_ptr_ff <= scan_ptr_in;
         level_ff    <= level_in;
         run_len_ff  <= run_len_in;
         iss_cnt_ff  <= iss_cnt_in;
         cmp_cnt_ff  <= cmp_cnt_in;
         pend_ff     <= pend_in;
         found_ff    <= found_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff  <= req_in_byte;
         delim_ff <= req_delimiter;
      end
      out_byte_ff   <= out_byte_in;
      byte_valid_ff <= byte_valid_in;
      last_ff       <= last_in;
      accepted_ff   <= accepted_in;
      found_out_ff  <= found_out_in;
      level_out_ff  <= level_out_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_out_byte   = out_byte_ff;
   assign rsp_byte_valid = byte_valid_ff;
   assign rsp_last       = last_ff;
   assign rsp_accepted   = accepted_ff;
   assign rsp_found      = found_out_ff;
   assign rsp_level      = level_out_ff;

endmodule
